// File: hdl/tom_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the 2-opt tour move engine.
package tom_pkg;

    // Fixed field widths of the stream items.
    localparam int CITY_BITS        = 8;
    localparam int INDEX_BITS       = 8;
    localparam int VALUE_BITS       = 24;
    localparam int MODE_BITS        = 2;
    localparam int DELTA_BITS       = 26;
    localparam int LENGTH_BITS      = 32;
    localparam int IN_DATA_BITS     = 40;
    localparam int OUT_DATA_BITS    = 64;
    localparam int OUT_PAD_BITS     = OUT_DATA_BITS - DELTA_BITS - LENGTH_BITS - 2;

    // Distance table is addressed by a pair of city numbers.
    localparam int DIST_ADDR_BITS   = 2 * CITY_BITS;
    localparam int DIST_DEPTH       = 1 << DIST_ADDR_BITS;

    // Register file.
    localparam int APB_ADDR_BITS    = 3;
    localparam int APB_DATA_BITS    = 32;
    localparam int CITY_COUNT_BITS  = 9;
    localparam logic [CITY_COUNT_BITS-1:0] CITY_COUNT_RESET = 9'd4;
    localparam logic                 REG_CITY_COUNT   = 1'b0;
    localparam int MIN_CITIES       = 4;

    // Saturation limits, held wide so any accumulator fits below them.
    localparam logic signed [63:0] DELTA_FLOOR  = -64'sd33554432;
    localparam logic signed [63:0] LENGTH_CEIL  = 64'sh0000_0000_FFFF_FFFF;
    localparam logic [DELTA_BITS-1:0] DELTA_FLOOR_CODE = 26'h200_0000;

    // Item kinds.
    typedef enum logic [MODE_BITS-1:0] {
        MODE_LOAD_DIST = 2'd0,
        MODE_LOAD_TOUR = 2'd1,
        MODE_MOVE      = 2'd2,
        MODE_LENGTH    = 2'd3
    } mode_t;

    // Controls of the shared add/subtract unit.
    typedef struct packed {
        logic clear;
        logic en;
        logic sub;
    } acc_ctl_t;

    // Result flags from the sequencer.
    typedef struct packed {
        logic improved;
        logic status;
        logic is_length;
    } res_t;

endpackage

// File: hdl/tom_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module tom_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: hdl/tom_accum.sv
`timescale 1ns / 1ps
// Shared signed accumulator used for move deltas and tour length sums.
module tom_accum
    import tom_pkg::*;
#(
    parameter int DIST_BITS = 24,
    parameter int ACC_BITS  = 35
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  acc_ctl_t               ctl,
    input  logic [DIST_BITS-1:0]   operand,
    output logic                   acc_neg,
    output logic [DELTA_BITS-1:0]  delta,
    output logic [LENGTH_BITS-1:0] tour_length
);

    logic signed [ACC_BITS-1:0] acc_reg;
    logic signed [ACC_BITS-1:0] acc_next;
    logic signed [ACC_BITS-1:0] op_ext;
    logic signed [63:0]         acc_wide;

    // Distances are unsigned, so they enter with zero extension.
    assign op_ext = signed'(ACC_BITS'(operand));

    // One add or subtract per cycle.
    always_comb
    begin
        acc_next = acc_reg;
        if (ctl.clear)
        begin
            acc_next = '0;
        end
        else if (ctl.en)
        begin
            acc_next = ctl.sub ? (acc_reg - op_ext) : (acc_reg + op_ext);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
        end
        else
        begin
            acc_reg <= acc_next;
        end
    end

    // Saturate to the result field ranges.
    assign acc_wide    = 64'(acc_reg);
    assign acc_neg     = acc_reg[ACC_BITS-1];
    assign delta       = (acc_wide < DELTA_FLOOR) ? DELTA_FLOOR_CODE : acc_wide[DELTA_BITS-1:0];
    assign tour_length = (acc_wide > LENGTH_CEIL) ? '1 : acc_wide[LENGTH_BITS-1:0];

endmodule

// File: hdl/tom_seq.sv
`timescale 1ns / 1ps
// Sequencer: item decode, tour and table addressing, segment reversal.
module tom_seq
    import tom_pkg::*;
#(
    parameter int MAX_CITIES = 256,
    localparam int TAW       = $clog2(MAX_CITIES),
    localparam int NW        = $clog2(MAX_CITIES + 1)
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  mode_t                     in_mode,
    input  logic [INDEX_BITS-1:0]     first_index,
    input  logic [INDEX_BITS-1:0]     second_index,
    input  logic [CITY_BITS-1:0]      in_city,
    input  logic [NW-1:0]             n,
    input  logic [CITY_BITS-1:0]      tour_rdata,
    output logic                      tour_we,
    output logic [TAW-1:0]            tour_waddr,
    output logic [CITY_BITS-1:0]      tour_wdata,
    output logic [TAW-1:0]            tour_raddr,
    output logic                      dist_we,
    output logic [DIST_ADDR_BITS-1:0] dist_waddr,
    output logic [DIST_ADDR_BITS-1:0] dist_raddr,
    output acc_ctl_t                  acc_ctl,
    input  logic                      acc_neg,
    input  logic                      out_free,
    output logic                      done,
    output res_t                      res
);

    localparam int CNTW = NW + 1;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_TREAD = 7'b0000010,
        ST_DREAD = 7'b0000100,
        ST_CHECK = 7'b0001000,
        ST_SWAP  = 7'b0010000,
        ST_LEN   = 7'b0100000,
        ST_FIN   = 7'b1000000
    } state_t;

    state_t                  state_reg, state_next;
    mode_t                   mode_reg, mode_next;
    logic [CNTW-1:0]         cnt_reg, cnt_next;
    logic [INDEX_BITS-1:0]   a_reg, a_next;
    logic [INDEX_BITS-1:0]   b_reg, b_next;
    logic [CITY_BITS-1:0]    cs_reg, cs_next;
    logic [CITY_BITS-1:0]    cp_reg, cp_next;
    logic [CITY_BITS-1:0]    ce_reg, ce_next;
    logic [CITY_BITS-1:0]    cn_reg, cn_next;
    logic [CITY_BITS-1:0]    lprev_reg, lprev_next;
    logic [CITY_BITS-1:0]    tmp_reg, tmp_next;
    logic [TAW-1:0]          i_reg, i_next;
    logic [TAW-1:0]          j_reg, j_next;
    logic [TAW-1:0]          ip_reg, ip_next;
    logic [TAW-1:0]          jp_reg, jp_next;
    logic                    live_reg, live_next;
    logic                    have_prev_reg, have_prev_next;
    logic                    ph_reg, ph_next;
    logic                    en_reg, en_next;
    logic                    sub_reg, sub_next;
    logic                    improved_reg, improved_next;
    logic                    status_reg, status_next;
    logic                    accept;
    logic                    move_ok;
    logic                    acc_clear;
    logic [TAW-1:0]          pred_pos;
    logic [CNTW-1:0]         len_last;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;

    // A move needs start < end < n-1.
    assign move_ok  = (first_index < second_index)
                      && ((32'(second_index) + 32'd1) < 32'(n));
    // Position before the segment start wraps to the last tour position.
    assign pred_pos = (a_reg == '0) ? TAW'(n - NW'(1)) : TAW'(a_reg - 8'd1);
    assign len_last = CNTW'(n) + CNTW'(2);

    // Next-state and datapath control.
    always_comb
    begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        cnt_next       = cnt_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        cs_next        = cs_reg;
        cp_next        = cp_reg;
        ce_next        = ce_reg;
        cn_next        = cn_reg;
        lprev_next     = lprev_reg;
        tmp_next       = tmp_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        ip_next        = ip_reg;
        jp_next        = jp_reg;
        live_next      = live_reg;
        have_prev_next = have_prev_reg;
        ph_next        = ph_reg;
        en_next        = 1'b0;
        sub_next       = 1'b0;
        improved_next  = improved_reg;
        status_next    = status_reg;
        acc_clear      = 1'b0;
        tour_we        = 1'b0;
        tour_waddr     = TAW'(first_index);
        tour_wdata     = in_city;
        tour_raddr     = '0;
        dist_we        = 1'b0;
        dist_waddr     = {first_index, second_index};
        dist_raddr     = {cs_reg, cn_reg};
        done           = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    mode_next     = in_mode;
                    a_next        = first_index;
                    b_next        = second_index;
                    improved_next = 1'b0;
                    status_next   = 1'b0;
                    cnt_next      = '0;
                    acc_clear     = 1'b1;
                    unique case (in_mode)
                        MODE_LOAD_DIST:
                        begin
                            dist_we    = 1'b1;
                            state_next = ST_FIN;
                        end
                        MODE_LOAD_TOUR:
                        begin
                            tour_we    = (32'(first_index) < MAX_CITIES);
                            state_next = ST_FIN;
                        end
                        MODE_MOVE:
                        begin
                            if (move_ok)
                            begin
                                state_next = ST_TREAD;
                            end
                            else
                            begin
                                status_next = 1'b1;
                                state_next  = ST_FIN;
                            end
                        end
                        MODE_LENGTH:
                        begin
                            state_next = ST_LEN;
                        end
                        default:
                        begin
                            state_next = ST_FIN;
                        end
                    endcase
                end
            end

            // Fetch the four cities around the segment, one read a cycle.
            ST_TREAD:
            begin
                case (cnt_reg[2:0])
                    3'd0:    tour_raddr = TAW'(a_reg);
                    3'd1:    tour_raddr = pred_pos;
                    3'd2:    tour_raddr = TAW'(b_reg);
                    3'd3:    tour_raddr = TAW'(b_reg + 8'd1);
                    default: tour_raddr = TAW'(a_reg);
                endcase
                case (cnt_reg[2:0])
                    3'd1:    cs_next = tour_rdata;
                    3'd2:    cp_next = tour_rdata;
                    3'd3:    ce_next = tour_rdata;
                    3'd4:    cn_next = tour_rdata;
                    default: cs_next = cs_reg;
                endcase
                if (cnt_reg == CNTW'(4))
                begin
                    cnt_next   = '0;
                    state_next = ST_DREAD;
                end
                else
                begin
                    cnt_next = cnt_reg + CNTW'(1);
                end
            end

            // Two new edges are added, two old edges subtracted.
            ST_DREAD:
            begin
                case (cnt_reg[1:0])
                    2'd0:    dist_raddr = {cs_reg, cn_reg};
                    2'd1:    dist_raddr = {cp_reg, ce_reg};
                    2'd2:    dist_raddr = {cp_reg, cs_reg};
                    default: dist_raddr = {ce_reg, cn_reg};
                endcase
                en_next  = (cnt_reg < CNTW'(4));
                sub_next = cnt_reg[1];
                if (cnt_reg == CNTW'(4))
                begin
                    state_next = ST_CHECK;
                end
                else
                begin
                    cnt_next = cnt_reg + CNTW'(1);
                end
            end

            // Accept the move only on a strictly negative change.
            ST_CHECK:
            begin
                if (acc_neg)
                begin
                    improved_next  = 1'b1;
                    i_next         = TAW'(a_reg);
                    j_next         = TAW'(b_reg);
                    live_next      = 1'b1;
                    have_prev_next = 1'b0;
                    ph_next        = 1'b0;
                    state_next     = ST_SWAP;
                end
                else
                begin
                    state_next = ST_FIN;
                end
            end

            // Swap rounds: reads of this pair overlap writes of the last.
            ST_SWAP:
            begin
                if (!ph_reg)
                begin
                    tour_raddr = i_reg;
                    if (have_prev_reg)
                    begin
                        tour_we    = 1'b1;
                        tour_waddr = ip_reg;
                        tour_wdata = tour_rdata;
                    end
                    ph_next = 1'b1;
                end
                else
                begin
                    tour_raddr = j_reg;
                    tmp_next   = tour_rdata;
                    if (have_prev_reg)
                    begin
                        tour_we    = 1'b1;
                        tour_waddr = jp_reg;
                        tour_wdata = tmp_reg;
                    end
                    ph_next        = 1'b0;
                    have_prev_next = live_reg;
                    ip_next        = i_reg;
                    jp_next        = j_reg;
                    i_next         = i_reg + TAW'(1);
                    j_next         = j_reg - TAW'(1);
                    live_next      = live_reg
                                     && (({1'b0, i_reg} + (TAW + 1)'(2)) < {1'b0, j_reg});
                    if (!live_reg)
                    begin
                        state_next = ST_FIN;
                    end
                end
            end

            // Walk the closed tour starting from the last position.
            ST_LEN:
            begin
                tour_raddr = (cnt_reg == '0) ? TAW'(n - NW'(1)) : TAW'(cnt_reg - CNTW'(1));
                dist_raddr = {lprev_reg, tour_rdata};
                if (cnt_reg == CNTW'(1))
                begin
                    lprev_next = tour_rdata;
                end
                if ((cnt_reg >= CNTW'(2)) && (cnt_reg != len_last))
                begin
                    en_next    = 1'b1;
                    lprev_next = tour_rdata;
                end
                if (cnt_reg == len_last)
                begin
                    state_next = ST_FIN;
                end
                else
                begin
                    cnt_next = cnt_reg + CNTW'(1);
                end
            end

            ST_FIN:
            begin
                done = out_free;
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            mode_reg      <= MODE_LOAD_DIST;
            cnt_reg       <= '0;
            live_reg      <= 1'b0;
            have_prev_reg <= 1'b0;
            ph_reg        <= 1'b0;
            en_reg        <= 1'b0;
            sub_reg       <= 1'b0;
            improved_reg  <= 1'b0;
            status_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mode_reg      <= mode_next;
            cnt_reg       <= cnt_next;
            live_reg      <= live_next;
            have_prev_reg <= have_prev_next;
            ph_reg        <= ph_next;
            en_reg        <= en_next;
            sub_reg       <= sub_next;
            improved_reg  <= improved_next;
            status_reg    <= status_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        a_reg     <= a_next;
        b_reg     <= b_next;
        cs_reg    <= cs_next;
        cp_reg    <= cp_next;
        ce_reg    <= ce_next;
        cn_reg    <= cn_next;
        lprev_reg <= lprev_next;
        tmp_reg   <= tmp_next;
        i_reg     <= i_next;
        j_reg     <= j_next;
        ip_reg    <= ip_next;
        jp_reg    <= jp_next;
    end

    // The enable and subtract controls are registered to line up with the registered table read data.
    assign acc_ctl.clear = acc_clear;
    assign acc_ctl.en    = en_reg;
    assign acc_ctl.sub   = sub_reg;

    assign res.improved  = improved_reg;
    assign res.status    = status_reg;
    assign res.is_length = (mode_reg == MODE_LENGTH);

`ifndef SYNTHESIS
    // Each live swap pair has its low position strictly below its high one.
    a_swap_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SWAP && live_reg) |-> (i_reg < j_reg))
        else $error("swap pair out of order");

    // An applied move always comes from a negative change.
    a_improve_neg: assert property (@(posedge clk) disable iff (!rst_n)
        (done && res.improved) |-> acc_neg)
        else $error("move applied without a gain");

    // A move with bad positions goes straight to the result with the flag set.
    a_bad_move: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && in_mode == MODE_MOVE && !move_ok) |=> (state_reg == ST_FIN && status_reg))
        else $error("invalid move not flagged");
`endif

endmodule

// File: hdl/two_opt_tour_move_engine.sv
`timescale 1ns / 1ps
// Top level of the 2-opt tour move engine: register port, memories, result register.
//
//  Channel   Dir  Handshake                     Contents
//  s_*       in   s_tvalid / s_tready           tdata: first_index, second_index, value;
//                                               tuser: mode
//  m_*       out  m_tvalid / m_tready           tdata: delta, improved, tour_length, status
//  APB       in   psel, penable, pwrite, pready city_count at byte address 0
//
//  Loads and invalid moves go straight to the result. A move reads its four tour cities
//  and four table words in turn, an applied one then swaps the segment pair by pair, and
//  the tour sum walks all positions: the tour memory has one read port, the adder is shared.
//  One item is in flight at a time; s_tready is low while it is worked on, and a
//  finished item waits in the sequencer until the output register is free.
//  Reset sets city_count to 4; the tables hold nothing defined until written.
module two_opt_tour_move_engine
    import tom_pkg::*;
#(
    parameter int MAX_CITIES = 256,
    parameter int DIST_BITS  = 24
) (
    input  logic                     clk,
    input  logic                     rst_n,
    // Input items.
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [IN_DATA_BITS-1:0]  s_tdata,   // first_index, second_index, value (low first)
    input  logic [MODE_BITS-1:0]     s_tuser,   // mode
    // Result items.
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [OUT_DATA_BITS-1:0] m_tdata,   // delta, improved, tour_length, status, zeros
    // Register port.
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [APB_ADDR_BITS-1:0] paddr,
    input  logic [APB_DATA_BITS-1:0] pwdata,
    output logic [APB_DATA_BITS-1:0] prdata,
    output logic                     pready
);

    localparam int TAW      = $clog2(MAX_CITIES);
    localparam int NW       = $clog2(MAX_CITIES + 1);
    localparam int ACC_BITS = DIST_BITS + NW + 2;

    logic [CITY_COUNT_BITS-1:0] city_count_reg;
    logic [NW-1:0]              n_eff;
    logic [INDEX_BITS-1:0]      first_index;
    logic [INDEX_BITS-1:0]      second_index;
    logic [VALUE_BITS-1:0]      value;
    logic                       tour_we;
    logic [TAW-1:0]             tour_waddr;
    logic [CITY_BITS-1:0]       tour_wdata;
    logic [TAW-1:0]             tour_raddr;
    logic [CITY_BITS-1:0]       tour_rdata;
    logic                       dist_we;
    logic [DIST_ADDR_BITS-1:0]  dist_waddr;
    logic [DIST_ADDR_BITS-1:0]  dist_raddr;
    logic [DIST_BITS-1:0]       dist_rdata;
    acc_ctl_t                   acc_ctl;
    logic                       acc_neg;
    logic [DELTA_BITS-1:0]      delta_sat;
    logic [LENGTH_BITS-1:0]     length_sat;
    logic                       done;
    res_t                       res;
    logic                       out_free;
    logic                       out_valid_reg, out_valid_next;
    logic [OUT_DATA_BITS-1:0]   out_data_reg;
    logic                       cfg_write;

    assign first_index  = s_tdata[7:0];
    assign second_index = s_tdata[15:8];
    assign value        = s_tdata[39:16];

    // Register port: writes land on the access cycle.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready
                       && (paddr[APB_ADDR_BITS-1:2] == REG_CITY_COUNT);
    assign prdata    = (paddr[APB_ADDR_BITS-1:2] == REG_CITY_COUNT)
                       ? APB_DATA_BITS'(city_count_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            city_count_reg <= CITY_COUNT_RESET;
        end
        else if (cfg_write)
        begin
            city_count_reg <= pwdata[CITY_COUNT_BITS-1:0];
        end
    end

    // City count clamped to the supported range.
    always_comb
    begin
        if (32'(city_count_reg) < MIN_CITIES)
        begin
            n_eff = NW'(MIN_CITIES);
        end
        else if (32'(city_count_reg) > MAX_CITIES)
        begin
            n_eff = NW'(MAX_CITIES);
        end
        else
        begin
            n_eff = NW'(city_count_reg);
        end
    end

    tom_seq #(
        .MAX_CITIES (MAX_CITIES)
    ) u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .in_mode      (mode_t'(s_tuser)),
        .first_index  (first_index),
        .second_index (second_index),
        .in_city      (value[CITY_BITS-1:0]),
        .n            (n_eff),
        .tour_rdata   (tour_rdata),
        .tour_we      (tour_we),
        .tour_waddr   (tour_waddr),
        .tour_wdata   (tour_wdata),
        .tour_raddr   (tour_raddr),
        .dist_we      (dist_we),
        .dist_waddr   (dist_waddr),
        .dist_raddr   (dist_raddr),
        .acc_ctl      (acc_ctl),
        .acc_neg      (acc_neg),
        .out_free     (out_free),
        .done         (done),
        .res          (res)
    );

    tom_ram #(
        .WIDTH (CITY_BITS),
        .DEPTH (MAX_CITIES)
    ) u_tour_ram (
        .clk   (clk),
        .we    (tour_we),
        .waddr (tour_waddr),
        .wdata (tour_wdata),
        .raddr (tour_raddr),
        .rdata (tour_rdata)
    );

    tom_ram #(
        .WIDTH (DIST_BITS),
        .DEPTH (DIST_DEPTH)
    ) u_dist_ram (
        .clk   (clk),
        .we    (dist_we),
        .waddr (dist_waddr),
        .wdata (DIST_BITS'(value)),
        .raddr (dist_raddr),
        .rdata (dist_rdata)
    );

    tom_accum #(
        .DIST_BITS (DIST_BITS),
        .ACC_BITS  (ACC_BITS)
    ) u_accum (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (acc_ctl),
        .operand     (dist_rdata),
        .acc_neg     (acc_neg),
        .delta       (delta_sat),
        .tour_length (length_sat)
    );

    // Output register holds one result item until it is taken.
    assign out_free = !out_valid_reg || m_tready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (done)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (done)
        begin
            out_data_reg <= {
                {OUT_PAD_BITS{1'b0}},
                res.status,
                res.is_length ? length_sat : {LENGTH_BITS{1'b0}},
                res.improved,
                res.improved ? delta_sat : {DELTA_BITS{1'b0}}
            };
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

// File: test/two_opt_move_checker.sv
`timescale 1ns / 1ps
// Checker for the 2-opt tour move engine: mirrors its state, predicts each result and compares.
module two_opt_move_checker
    import tom_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     s_tvalid,
    input  logic                     s_tready,
    input  logic [IN_DATA_BITS-1:0]  s_tdata,   // first_index, second_index, value (low first)
    input  logic [MODE_BITS-1:0]     s_tuser,   // mode
    input  logic                     m_tvalid,
    input  logic                     m_tready,
    input  logic [OUT_DATA_BITS-1:0] m_tdata,   // delta, improved, tour_length, status, zeros
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [APB_ADDR_BITS-1:0] paddr,
    input  logic [APB_DATA_BITS-1:0] pwdata,
    input  logic                     pready,
    output int                       failures,
    output int                       pending_results
);

    localparam int TOUR_SLOTS = 256;
    localparam logic [APB_ADDR_BITS-1:0] CITY_COUNT_ADDR = APB_ADDR_BITS'(4 * REG_CITY_COUNT);
    localparam longint DELTA_LOW = -(64'sd1 <<< (DELTA_BITS - 1));
    localparam longint unsigned LENGTH_MAX = 64'hFFFF_FFFF;

    // One result item, split into its fields.
    typedef struct packed {
        logic signed [DELTA_BITS-1:0] delta;
        logic                         improved;
        logic [LENGTH_BITS-1:0]       tour_length;
        logic                         status;
    } move_result_t;

    // Mirror of the distance table, the tour and the city count.
    logic [VALUE_BITS-1:0]      dist_mirror [DIST_DEPTH];
    logic [CITY_BITS-1:0]       tour_mirror [TOUR_SLOTS];
    logic [CITY_COUNT_BITS-1:0] city_count_mirror;
    move_result_t               expected_results [$];

    initial failures = 0;
    initial pending_results = 0;

    function automatic longint unsigned leg_len(logic [CITY_BITS-1:0] from_city,
                                                logic [CITY_BITS-1:0] to_city);
        return longint'(dist_mirror[{from_city, to_city}]);
    endfunction

    // Applies one input item to the mirrored state and returns the result it should give.
    function automatic move_result_t apply_item(mode_t md, logic [INDEX_BITS-1:0] a,
                                                logic [INDEX_BITS-1:0] b,
                                                logic [VALUE_BITS-1:0] v);
        move_result_t         r;
        int unsigned          n;
        int unsigned          i;
        int unsigned          j;
        logic [CITY_BITS-1:0] cs;
        logic [CITY_BITS-1:0] cp;
        logic [CITY_BITS-1:0] ce;
        logic [CITY_BITS-1:0] cn;
        logic [CITY_BITS-1:0] held;
        logic [CITY_BITS-1:0] prev;
        longint unsigned      added;
        longint unsigned      removed;
        longint unsigned      sum;
        longint               gain;
        r = '0;
        n = city_count_mirror;
        if (n < MIN_CITIES) n = MIN_CITIES;
        if (n > TOUR_SLOTS) n = TOUR_SLOTS;
        case (md)
            MODE_LOAD_DIST: dist_mirror[{a, b}] = v;
            MODE_LOAD_TOUR: tour_mirror[a] = v[CITY_BITS-1:0];
            MODE_MOVE:
            begin
                i = a;
                j = b;
                if (!(i < j && j < n - 1)) begin
                    r.status = 1'b1;
                end else begin
                    // The predecessor of position 0 is the last position in use.
                    cs = tour_mirror[i];
                    cp = tour_mirror[(i == 0) ? n - 1 : i - 1];
                    ce = tour_mirror[j];
                    cn = tour_mirror[j + 1];
                    added   = leg_len(cs, cn) + leg_len(cp, ce);
                    removed = leg_len(cp, cs) + leg_len(ce, cn);
                    if (added < removed) begin
                        gain = -longint'(removed - added);
                        if (gain < DELTA_LOW) gain = DELTA_LOW;
                        while (i < j) begin
                            held = tour_mirror[i];
                            tour_mirror[i] = tour_mirror[j];
                            tour_mirror[j] = held;
                            i++;
                            j--;
                        end
                        r.delta    = gain[DELTA_BITS-1:0];
                        r.improved = 1'b1;
                    end
                end
            end
            default:
            begin
                // Closed tour: start from the leg that enters position 0.
                sum  = 0;
                prev = tour_mirror[n - 1];
                for (i = 0; i < n; i++) begin
                    sum += leg_len(prev, tour_mirror[i]);
                    prev = tour_mirror[i];
                end
                if (sum > LENGTH_MAX) sum = LENGTH_MAX;
                r.tour_length = sum[LENGTH_BITS-1:0];
            end
        endcase
        return r;
    endfunction

    function automatic void flag_mismatch(string field, longint want, longint got);
        failures++;
        $error("%s mismatch: expected %0d, actual %0d", field, want, got);
    endfunction

    // Watch both channels and the register port at every rising edge.
    always @(posedge clk) begin : monitor
        move_result_t want;
        move_result_t got;
        if (!rst_n) begin
            city_count_mirror = CITY_COUNT_RESET;
            expected_results.delete();
        end else begin
            if (psel && penable && pwrite && pready && paddr == CITY_COUNT_ADDR)
                city_count_mirror = pwdata[CITY_COUNT_BITS-1:0];

            // Results are checked before a new item is taken in at the same edge.
            if (m_tvalid && m_tready) begin
                got.delta       = m_tdata[DELTA_BITS-1:0];
                got.improved    = m_tdata[DELTA_BITS];
                got.tour_length = m_tdata[DELTA_BITS+1 +: LENGTH_BITS];
                got.status      = m_tdata[DELTA_BITS+1+LENGTH_BITS];
                if (expected_results.size() == 0) begin
                    flag_mismatch("unexpected result item, status", 0, longint'(got.status));
                end else begin
                    want = expected_results.pop_front();
                    if (got.delta !== want.delta)
                        flag_mismatch("delta", longint'($signed(want.delta)),
                                      longint'($signed(got.delta)));
                    if (got.improved !== want.improved)
                        flag_mismatch("improved", longint'(want.improved),
                                      longint'(got.improved));
                    if (got.tour_length !== want.tour_length)
                        flag_mismatch("tour_length", longint'(want.tour_length),
                                      longint'(got.tour_length));
                    if (got.status !== want.status)
                        flag_mismatch("status", longint'(want.status), longint'(got.status));
                end
            end

            if (s_tvalid && s_tready)
                expected_results.push_back(apply_item(mode_t'(s_tuser),
                                                      s_tdata[INDEX_BITS-1:0],
                                                      s_tdata[INDEX_BITS +: INDEX_BITS],
                                                      s_tdata[2*INDEX_BITS +: VALUE_BITS]));
        end
        pending_results <= expected_results.size();
    end

endmodule

// File: test/tb_two_opt_tour_move_engine.sv
`timescale 1ns / 1ps
// Testbench top for the 2-opt tour move engine: clock, reset, stimulus and the verdict.
module tb_two_opt_tour_move_engine;
    import tom_pkg::*;

    localparam int TOUR_SLOTS    = 256;
    localparam int POOL_SIZE     = 8;
    localparam int RANDOM_ITEMS  = 1150;
    localparam int HOLD_CYCLES   = 400;
    localparam int DRAIN_CYCLES  = 300;
    localparam int LIMIT_CYCLES  = 3_000_000;
    localparam logic [APB_ADDR_BITS-1:0] CITY_COUNT_ADDR = APB_ADDR_BITS'(4 * REG_CITY_COUNT);

    logic                     clk;
    logic                     rst_n    = 1'b0;
    logic                     s_tvalid = 1'b0;
    logic                     s_tready;
    logic [IN_DATA_BITS-1:0]  s_tdata  = '0;   // first_index, second_index, value (low first)
    logic [MODE_BITS-1:0]     s_tuser  = '0;   // mode
    logic                     m_tvalid;
    logic                     m_tready = 1'b0;
    logic [OUT_DATA_BITS-1:0] m_tdata;         // delta, improved, tour_length, status, zeros
    logic                     psel     = 1'b0;
    logic                     penable  = 1'b0;
    logic                     pwrite   = 1'b0;
    logic [APB_ADDR_BITS-1:0] paddr    = '0;
    logic [APB_DATA_BITS-1:0] pwdata   = '0;
    logic [APB_DATA_BITS-1:0] prdata;
    logic                     pready;

    int                       failures;
    int                       pending_results;
    int                       cycles        = 0;
    bit                       steady        = 1'b0;
    bit                       hold_request  = 1'b0;
    logic [CITY_BITS-1:0]     city_pool [POOL_SIZE];

    two_opt_tour_move_engine uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    two_opt_move_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .pready          (pready),
        .failures        (failures),
        .pending_results (pending_results)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Run limit.
    initial
    begin
        while (cycles < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("FAIL");
        $finish;
    end

    // Result side: random stalls, one long hold-off while the sender keeps offering.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            m_tready <= steady || ($urandom_range(99) >= 29);
        end
    end

    function automatic logic [CITY_BITS-1:0] pool_city();
        return city_pool[$urandom_range(POOL_SIZE - 1)];
    endfunction

    // Offers one item and returns at the edge where it is taken.
    task automatic send_item(input mode_t md, input logic [INDEX_BITS-1:0] a,
                             input logic [INDEX_BITS-1:0] b, input logic [VALUE_BITS-1:0] v);
        if (!steady)
        begin
            while ($urandom_range(99) < 29)
            begin
                s_tvalid <= 1'b0;
                @(posedge clk);
            end
        end
        s_tvalid <= 1'b1;
        s_tuser  <= md;
        s_tdata  <= {v, b, a};
        do @(posedge clk); while (!s_tready);
    endtask

    // Stops offering and waits until every expected result has come back.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_results != 0) @(posedge clk);
    endtask

    task automatic write_city_count(input logic [CITY_COUNT_BITS-1:0] count);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CITY_COUNT_ADDR;
        pwdata  <= APB_DATA_BITS'(count);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    initial
    begin : stimulus
        int                         k;
        int                         m;
        int                         n;
        int                         pick;
        int                         phase_len;
        int                         random_items;
        bit                         fresh;
        logic [CITY_BITS-1:0]       c;
        logic [CITY_COUNT_BITS-1:0] count;
        logic [INDEX_BITS-1:0]      a;
        logic [INDEX_BITS-1:0]      b;
        logic [VALUE_BITS-1:0]      v;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // A small set of distinct cities, with both extreme city numbers in it.
        city_pool[0] = '0;
        city_pool[1] = '1;
        for (k = 2; k < POOL_SIZE; k++)
        begin
            fresh = 1'b0;
            while (!fresh)
            begin
                c = CITY_BITS'($urandom_range(1, 254));
                fresh = 1'b1;
                for (m = 0; m < k; m++)
                    if (city_pool[m] == c) fresh = 1'b0;
            end
            city_pool[k] = c;
        end

        // Fill every distance between pool cities and every tour position.
        for (k = 0; k < POOL_SIZE; k++)
            for (m = 0; m < POOL_SIZE; m++)
                send_item(MODE_LOAD_DIST, city_pool[k], city_pool[m], VALUE_BITS'($urandom()));
        for (k = 0; k < TOUR_SLOTS; k++)
            send_item(MODE_LOAD_TOUR, INDEX_BITS'(k), INDEX_BITS'($urandom()),
                      {16'($urandom()), pool_city()});

        // Extreme distances and tour entries, upper value bits set on a city load.
        send_item(MODE_LOAD_DIST, '1, '1, '1);
        send_item(MODE_LOAD_DIST, '0, '0, '0);
        send_item(MODE_LOAD_TOUR, '1, '0, '1);
        send_item(MODE_LOAD_TOUR, '0, '1, 24'hFFFF00);

        // A move with the largest possible gain, then the same move rejected.
        for (k = 0; k < 4; k++)
            send_item(MODE_LOAD_TOUR, INDEX_BITS'(k), '0, VALUE_BITS'(city_pool[k + 2]));
        send_item(MODE_LOAD_DIST, city_pool[3], city_pool[5], '0);
        send_item(MODE_LOAD_DIST, city_pool[2], city_pool[4], '0);
        send_item(MODE_LOAD_DIST, city_pool[2], city_pool[3], '1);
        send_item(MODE_LOAD_DIST, city_pool[4], city_pool[5], '1);
        send_item(MODE_MOVE, 8'd1, 8'd2, '0);
        send_item(MODE_LENGTH, '0, '0, '1);
        send_item(MODE_MOVE, 8'd1, 8'd2, '1);
        // Start at position 0, so the predecessor wraps to the last position.
        send_item(MODE_MOVE, 8'd0, 8'd1, VALUE_BITS'($urandom()));

        // Index pairs that break start < end < count - 1.
        send_item(MODE_MOVE, 8'd0, 8'd3, '0);
        send_item(MODE_MOVE, 8'd2, 8'd2, '0);
        send_item(MODE_MOVE, 8'd3, 8'd1, '0);
        send_item(MODE_MOVE, '1, '1, '1);

        // A tie: equal sums leave the tour as it is.
        for (k = 0; k < 4; k++)
            send_item(MODE_LOAD_TOUR, INDEX_BITS'(k), '0, VALUE_BITS'(city_pool[6]));
        send_item(MODE_MOVE, 8'd0, 8'd2, '0);
        send_item(MODE_LENGTH, '0, '0, '0);

        // City counts outside the legal range are clamped.
        wait_drained();
        write_city_count(9'd0);
        send_item(MODE_LENGTH, '0, '0, '0);
        wait_drained();
        write_city_count(9'd511);
        send_item(MODE_MOVE, 8'd0, 8'd254, '0);
        send_item(MODE_MOVE, 8'd0, 8'd255, '0);
        wait_drained();
        write_city_count(9'd257);
        send_item(MODE_LENGTH, '0, '0, '0);

        // Random phases, each under its own city count.
        random_items = 0;
        while (random_items < RANDOM_ITEMS)
        begin
            wait_drained();
            pick = $urandom_range(99);
            if (pick < 55)
                count = CITY_COUNT_BITS'($urandom_range(4, 12));
            else if (pick < 75)
                count = CITY_COUNT_BITS'($urandom_range(13, 64));
            else if (pick < 85)
                count = CITY_COUNT_BITS'($urandom_range(65, 255));
            else if (pick < 92)
                count = CITY_COUNT_BITS'(TOUR_SLOTS);
            else if ($urandom_range(1) == 0)
                count = CITY_COUNT_BITS'($urandom_range(0, 3));
            else
                count = CITY_COUNT_BITS'($urandom_range(257, 511));
            write_city_count(count);
            n = (count < MIN_CITIES) ? MIN_CITIES : (count > TOUR_SLOTS) ? TOUR_SLOTS : count;

            phase_len = $urandom_range(30, 120);
            for (k = 0; k < phase_len && random_items < RANDOM_ITEMS; k++)
            begin
                steady = (random_items >= 600 && random_items < 800);
                if (random_items == 300) hold_request = 1'b1;
                pick = $urandom_range(99);
                a = INDEX_BITS'($urandom());
                b = INDEX_BITS'($urandom());
                v = VALUE_BITS'($urandom());
                if (pick < 60)
                begin
                    // Mostly legal moves; the rest use any index pair.
                    if ($urandom_range(99) < 85)
                    begin
                        a = INDEX_BITS'($urandom_range(0, n - 3));
                        b = INDEX_BITS'($urandom_range(a + 1, n - 2));
                    end
                    send_item(MODE_MOVE, a, b, v);
                end
                else if (pick < 70)
                begin
                    send_item(MODE_LENGTH, a, b, v);
                end
                else if (pick < 85)
                begin
                    if ($urandom_range(99) < 75)
                        a = INDEX_BITS'($urandom_range(0, n - 1));
                    v[CITY_BITS-1:0] = pool_city();
                    send_item(MODE_LOAD_TOUR, a, b, v);
                end
                else
                begin
                    // Table loads mostly between pool cities, sometimes anywhere.
                    if ($urandom_range(99) < 80)
                    begin
                        a = pool_city();
                        b = pool_city();
                    end
                    if ($urandom_range(9) == 0)
                        v = ($urandom_range(1) == 0) ? '0 : '1;
                    send_item(MODE_LOAD_DIST, a, b, v);
                end
                random_items++;
            end
        end
        steady = 1'b0;

        // Let every result come back, then give a stray one time to show up.
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (failures == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
